[hw/rtl/assert_macros.svh]
// Assertion macros for the top level RTL file of the pair energy block.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define LJ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lj pair energy assertion failed");
// Check a property on every rising edge, reset included
`define LJ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lj pair energy assertion failed");
`else
`define LJ_ASSERT(lbl, clk, rst_n, prop)
`define LJ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hw/rtl/lj_pkg.sv]
// Shared widths, pipeline depths, register codes and limits of the pair energy block.
// No dependencies; imported by lj_fold, lj_mulq and the top level.
`default_nettype none

package lj_pkg;

  // Field widths
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned BOX_W       = 31;
  localparam int unsigned CUT_W       = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  // Minimum-image fold: restoring division, a few quotient bits per stage
  localparam int unsigned FOLD_STEP   = 4;
  localparam int unsigned FOLD_STAGES = (COORD_WIDTH + FOLD_STEP - 1) / FOLD_STEP;
  localparam int unsigned FOLD_LAT    = FOLD_STAGES + 2;

  // Reciprocal of the squared distance: 2^64 / s, a few bits per stage
  localparam int unsigned RECIP_STEP   = 4;
  localparam int unsigned RECIP_STAGES = WORD_W / RECIP_STEP;

  // Split 64x64 fixed-point multiply
  localparam int unsigned MUL_LAT = 2;

  // Sideband line from the distance sum to the last product
  localparam int unsigned SB_LEN     = RECIP_STAGES + 3 * MUL_LAT + 1;
  localparam int unsigned PIPE_DEPTH = FOLD_LAT + RECIP_STAGES + 3 * MUL_LAT + 4;

  // Register reset values
  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(655360);
  localparam logic [CUT_W-1:0] CUT_RESET = CUT_W'(409600);

  // Output limits
  localparam logic [WORD_W-1:0] WORD_MAX  = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] TERM_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] E_LIMIT   = 64'd2305843009213693951;
  localparam logic [WORD_W-1:0] V_LIMIT   = 64'd384307168202282325;

  // Configuration register codes
  typedef enum logic [1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2,
    REG_CUTOFF = 2'd3
  } cfg_reg_e;

  // Per-item flags that ride beside the reciprocal and product stages
  typedef struct packed {
    logic in_cut;
    logic near_zero;
  } sb_t;

endpackage

`default_nettype wire

[hw/rtl/lj_fold.sv]
// Minimum-image fold of one axis: difference, pipelined restoring division
// by the box length, round-half-even select. Depends on lj_pkg.
`default_nettype none

module lj_fold import lj_pkg::*; (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic signed [COORD_WIDTH-1:0] first_i,
  input  logic signed [COORD_WIDTH-1:0] second_i,
  input  logic        [BOX_W-1:0]       box_i,
  output logic        [COORD_WIDTH-1:0] dist_o
);

  logic [COORD_WIDTH-1:0] abs_q, abs_d;
  logic [BOX_W-1:0]       rem_q [FOLD_STAGES];
  logic [BOX_W-1:0]       rem_d [FOLD_STAGES];
  logic [COORD_WIDTH-1:0] num_q [FOLD_STAGES];
  logic [COORD_WIDTH-1:0] num_d [FOLD_STAGES];
  logic [COORD_WIDTH-1:0] raw_q [FOLD_STAGES];
  logic [COORD_WIDTH-1:0] raw_d [FOLD_STAGES];
  logic                   qlsb_q [FOLD_STAGES];
  logic                   qlsb_d [FOLD_STAGES];
  logic [COORD_WIDTH-1:0] dist_q, dist_d;

  // Form the magnitude of the axis difference
  always_comb begin
    logic signed [COORD_WIDTH:0] diff;
    diff  = {first_i[COORD_WIDTH-1], first_i} - {second_i[COORD_WIDTH-1], second_i};
    abs_d = diff[COORD_WIDTH] ? COORD_WIDTH'(-diff) : COORD_WIDTH'(diff);
  end

  // Advance the remainder a few quotient bits per stage
  always_comb begin
    logic [BOX_W-1:0]       r;
    logic [COORD_WIDTH-1:0] n;
    logic                   qb;
    logic [BOX_W:0]         t;
    for (int k = 0; k < FOLD_STAGES; k++) begin
      if (k == 0) begin
        r        = '0;
        n        = abs_q;
        qb       = 1'b0;
        raw_d[k] = abs_q;
      end else begin
        r        = rem_q[k-1];
        n        = num_q[k-1];
        qb       = qlsb_q[k-1];
        raw_d[k] = raw_q[k-1];
      end
      for (int i = 0; i < FOLD_STEP; i++) begin
        if (k * FOLD_STEP + i < COORD_WIDTH) begin
          t = {r, n[COORD_WIDTH-1]};
          n = n << 1;
          if (t >= {1'b0, box_i}) begin
            t  = t - {1'b0, box_i};
            qb = 1'b1;
          end else begin
            qb = 1'b0;
          end
          r = t[BOX_W-1:0];
        end
      end
      rem_d[k]  = r;
      num_d[k]  = n;
      qlsb_d[k] = qb;
    end
  end

  // Round half to even and take the folded magnitude; a zero box passes the raw magnitude
  always_comb begin
    logic [BOX_W:0]   twice;
    logic [BOX_W:0]   box_w;
    logic             round_up;
    logic [BOX_W-1:0] m;
    twice    = {rem_q[FOLD_STAGES-1], 1'b0};
    box_w    = {1'b0, box_i};
    round_up = (twice > box_w) || ((twice == box_w) && qlsb_q[FOLD_STAGES-1]);
    m        = round_up ? (box_i - rem_q[FOLD_STAGES-1]) : rem_q[FOLD_STAGES-1];
    if (box_i == '0) begin
      dist_d = raw_q[FOLD_STAGES-1];
    end else begin
      dist_d = COORD_WIDTH'(m);
    end
  end

  // Hold every stage while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      abs_q <= abs_d;
      for (int k = 0; k < FOLD_STAGES; k++) begin
        rem_q[k]  <= rem_d[k];
        num_q[k]  <= num_d[k];
        raw_q[k]  <= raw_d[k];
        qlsb_q[k] <= qlsb_d[k];
      end
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

[hw/rtl/lj_mulq.sv]
// Unsigned Q32.32 multiply floor(a*b / 2^32), clamped to all ones, in two stages:
// four 32x32 partial products, then the aligned sum. Depends on lj_pkg.
`default_nettype none

module lj_mulq import lj_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output logic [WORD_W-1:0] prod_o
);

  localparam int unsigned HALF = WORD_W / 2;

  logic [WORD_W-1:0] hh_q, hl_q, lh_q, ll_q;
  logic [WORD_W-1:0] prod_q, prod_d;

  // Sum the partial products and clamp on overflow
  always_comb begin
    logic [WORD_W+1:0] acc;
    acc = (WORD_W+2)'({hh_q[HALF-1:0], {HALF{1'b0}}}) + (WORD_W+2)'(hl_q)
        + (WORD_W+2)'(lh_q) + (WORD_W+2)'(ll_q[WORD_W-1:HALF]);
    if ((hh_q[WORD_W-1:HALF] != '0) || (acc[WORD_W+1:WORD_W] != '0)) begin
      prod_d = WORD_MAX;
    end else begin
      prod_d = acc[WORD_W-1:0];
    end
  end

  // Advance both stages together
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hh_q   <= a_i[WORD_W-1:HALF] * b_i[WORD_W-1:HALF];
      hl_q   <= a_i[WORD_W-1:HALF] * b_i[HALF-1:0];
      lh_q   <= a_i[HALF-1:0] * b_i[WORD_W-1:HALF];
      ll_q   <= a_i[HALF-1:0] * b_i[HALF-1:0];
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[hw/rtl/lennard_jones_pair_energy.sv]
// Top level of the 12-6 Lennard-Jones pair energy block with APB configuration.
// Depends on lj_pkg, lj_fold, lj_mulq and assert_macros.svh.
//
// One particle pair enters per clock cycle while the output is not stalled, and its
// energy and virial terms leave at the pipeline end; the depth is set by the two restoring
// dividers (the box fold, eight stages, and the 2^64/s reciprocal, sixteen stages,
// four bits a stage) plus three split 64-bit products of two stages each. A stall on
// the output holds the whole pipeline in place. Box lengths are unsigned Q15.16, a
// zero box leaves that axis unfolded; the cutoff is compared as a squared Q16.16
// value. Results are signed Q32.32, zero outside the cutoff, and saturate to the
// positive maximum with the saturated flag on overflow or a near-zero distance.
// Write registers only while no request is in flight.
`default_nettype none
`include "assert_macros.svh"

module lennard_jones_pair_energy import lj_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // Pair request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] first_z_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_z_i,
  // Result request
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [WORD_W-1:0]      energy_term_o,
  output logic signed [WORD_W-1:0]      virial_term_o,
  output logic                          within_cutoff_o,
  output logic                          saturated_o
);

  logic                   adv;
  logic [PIPE_DEPTH-1:0]  vld_q;
  logic [BOX_W-1:0]       box_x_q, box_y_q, box_z_q;
  logic [CUT_W-1:0]       cut_q;
  logic [COORD_WIDTH-1:0] dx, dy, dz;
  logic [WORD_W-1:0]      sqx_q, sqy_q, sqz_q;
  logic [WORD_W-1:0]      s_d;
  sb_t                    sb_d;
  sb_t                    sb_q [SB_LEN];
  logic [WORD_W-1:0]      s_q;
  logic [WORD_W-1:0]      rrem_q [RECIP_STAGES];
  logic [WORD_W-1:0]      rrem_d [RECIP_STAGES];
  logic [WORD_W-1:0]      rquo_q [RECIP_STAGES];
  logic [WORD_W-1:0]      rquo_d [RECIP_STAGES];
  logic [WORD_W-1:0]      rs_q [RECIP_STAGES];
  logic [WORD_W-1:0]      rs_d [RECIP_STAGES];
  logic [WORD_W-1:0]      r2i;
  logic [WORD_W-1:0]      r2i_dly_q [MUL_LAT];
  logic [WORD_W-1:0]      r4, r6, p;
  logic [WORD_W-1:0]      r6_dly_q [MUL_LAT];
  logic                   tiny_q, within_f_q, e_ge_q, v_big_q, v_ge_q;
  logic [WORD_W-1:0]      e_diff_q, v_diff_q;
  logic [WORD_W-1:0]      energy_q, energy_d, virial_q, virial_d;
  logic                   within_q, sat_q, sat_d;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= BOX_RESET;
      box_y_q <= BOX_RESET;
      box_z_q <= BOX_RESET;
      cut_q   <= CUT_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_BOX_X:  box_x_q <= pwdata[BOX_W-1:0];
        REG_BOX_Y:  box_y_q <= pwdata[BOX_W-1:0];
        REG_BOX_Z:  box_z_q <= pwdata[BOX_W-1:0];
        REG_CUTOFF: cut_q   <= pwdata[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_BOX_X:  prdata = DATA_W'(box_x_q);
      REG_BOX_Y:  prdata = DATA_W'(box_y_q);
      REG_BOX_Z:  prdata = DATA_W'(box_z_q);
      REG_CUTOFF: prdata = DATA_W'(cut_q);
      default:    prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless the result register is held
  assign adv        = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Fold each axis into the periodic box
  lj_fold u_fold_x (
    .clk_i, .adv_i(adv), .first_i(first_x_i), .second_i(second_x_i),
    .box_i(box_x_q), .dist_o(dx)
  );
  lj_fold u_fold_y (
    .clk_i, .adv_i(adv), .first_i(first_y_i), .second_i(second_y_i),
    .box_i(box_y_q), .dist_o(dy)
  );
  lj_fold u_fold_z (
    .clk_i, .adv_i(adv), .first_i(first_z_i), .second_i(second_z_i),
    .box_i(box_z_q), .dist_o(dz)
  );

  // Sum the squares modulo 2^64, test the cutoff and flag a near-zero distance
  always_comb begin
    s_d       = sqx_q + sqy_q + sqz_q;
    sb_d.in_cut    = s_d < {{(WORD_W-CUT_W-16){1'b0}}, cut_q, 16'b0};
    sb_d.near_zero = s_d[WORD_W-1:1] == '0;
  end

  // Reciprocal division 2^64 / s, four quotient bits a stage
  always_comb begin
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] sv;
    logic [WORD_W:0]   t;
    for (int k = 0; k < RECIP_STAGES; k++) begin
      if (k == 0) begin
        rem = WORD_W'(1);
        quo = '0;
        sv  = s_q;
      end else begin
        rem = rrem_q[k-1];
        quo = rquo_q[k-1];
        sv  = rs_q[k-1];
      end
      for (int i = 0; i < RECIP_STEP; i++) begin
        t = {rem, 1'b0};
        if (t >= {1'b0, sv}) begin
          t   = t - {1'b0, sv};
          quo = {quo[WORD_W-2:0], 1'b1};
        end else begin
          quo = {quo[WORD_W-2:0], 1'b0};
        end
        rem = t[WORD_W-1:0];
      end
      rrem_d[k] = rem;
      rquo_d[k] = quo;
      rs_d[k]   = sv;
    end
  end

  // Pin 1/r^2 to all ones for a squared distance below two LSBs
  assign r2i = sb_q[RECIP_STAGES].near_zero ? WORD_MAX : rquo_q[RECIP_STAGES-1];

  lj_mulq u_mul_r4 (.clk_i, .adv_i(adv), .a_i(r2i), .b_i(r2i), .prod_o(r4));
  lj_mulq u_mul_r6 (.clk_i, .adv_i(adv), .a_i(r4), .b_i(r2i_dly_q[MUL_LAT-1]), .prod_o(r6));
  lj_mulq u_mul_p  (.clk_i, .adv_i(adv), .a_i(r6), .b_i(r6), .prod_o(p));

  // Clamp, scale and sign the two terms
  always_comb begin
    logic [WORD_W-1:0] e_scaled;
    logic [WORD_W-1:0] v_scaled;
    logic              e_sat;
    logic              v_sat;
    e_scaled = e_diff_q << 2;
    v_scaled = (v_diff_q << 4) + (v_diff_q << 3);
    e_sat    = e_ge_q && (e_diff_q > E_LIMIT);
    v_sat    = v_big_q || (v_ge_q && (v_diff_q > V_LIMIT));
    if (!within_f_q) begin
      energy_d = '0;
      virial_d = '0;
      sat_d    = 1'b0;
    end else if (tiny_q) begin
      energy_d = TERM_MAX;
      virial_d = TERM_MAX;
      sat_d    = 1'b1;
    end else begin
      if (e_sat) begin
        energy_d = TERM_MAX;
      end else if (e_ge_q) begin
        energy_d = e_scaled;
      end else begin
        energy_d = '0 - e_scaled;
      end
      if (v_sat) begin
        virial_d = TERM_MAX;
      end else if (v_ge_q) begin
        virial_d = v_scaled;
      end else begin
        virial_d = '0 - v_scaled;
      end
      sat_d = e_sat || v_sat;
    end
  end

  // Datapath registers, held on a stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q <= dx * dx;
      sqy_q <= dy * dy;
      sqz_q <= dz * dz;
      s_q   <= s_d;
      sb_q[0] <= sb_d;
      for (int j = 1; j < SB_LEN; j++) begin
        sb_q[j] <= sb_q[j-1];
      end
      for (int k = 0; k < RECIP_STAGES; k++) begin
        rrem_q[k] <= rrem_d[k];
        rquo_q[k] <= rquo_d[k];
        rs_q[k]   <= rs_d[k];
      end
      r2i_dly_q[0] <= r2i;
      r6_dly_q[0]  <= r6;
      for (int j = 1; j < MUL_LAT; j++) begin
        r2i_dly_q[j] <= r2i_dly_q[j-1];
        r6_dly_q[j]  <= r6_dly_q[j-1];
      end
      // Compare and subtract ahead of the scaling
      within_f_q <= sb_q[SB_LEN-1].in_cut;
      tiny_q     <= sb_q[SB_LEN-1].near_zero || (r6_dly_q[MUL_LAT-1][WORD_W-1:48] != '0);
      e_ge_q     <= p >= r6_dly_q[MUL_LAT-1];
      e_diff_q   <= (p >= r6_dly_q[MUL_LAT-1]) ? (p - r6_dly_q[MUL_LAT-1])
                                               : (r6_dly_q[MUL_LAT-1] - p);
      v_big_q    <= p[WORD_W-1:WORD_W-2] != '0;
      v_ge_q     <= {p[WORD_W-2:0], 1'b0} >= r6_dly_q[MUL_LAT-1];
      v_diff_q   <= ({p[WORD_W-2:0], 1'b0} >= r6_dly_q[MUL_LAT-1])
                    ? ({p[WORD_W-2:0], 1'b0} - r6_dly_q[MUL_LAT-1])
                    : (r6_dly_q[MUL_LAT-1] - {p[WORD_W-2:0], 1'b0});
      energy_q   <= energy_d;
      virial_q   <= virial_d;
      within_q   <= within_f_q;
      sat_q      <= sat_d;
    end
  end

  assign out_valid_o     = vld_q[PIPE_DEPTH-1];
  assign energy_term_o   = energy_q;
  assign virial_term_o   = virial_q;
  assign within_cutoff_o = within_q;
  assign saturated_o     = sat_q;

  // Checks on the pipeline and the result flags
  `LJ_ASSERT(a_stall_holds, clk_i, rst_ni, !adv |=> $stable(vld_q))
  `LJ_ASSERT(a_outside_zero, clk_i, rst_ni, out_valid_o && !within_cutoff_o |-> energy_term_o == '0 && virial_term_o == '0 && !saturated_o)
  `LJ_ASSERT_ALWAYS(a_sat_within, clk_i, out_valid_o && saturated_o |-> within_cutoff_o)
  `LJ_ASSERT(a_neg_unsat, clk_i, rst_ni, out_valid_o && energy_term_o[WORD_W-1] |-> !saturated_o)

endmodule

`default_nettype wire
